/* hdl/tlik_pkg.sv */
// Package for the two-link inverse kinematics block.
// Holds widths, register indexes, status codes and the CORDIC arctangent table.
// Used by every module in the hdl folder.
package tlik_pkg;

  localparam int CoordWidth  = 16;
  localparam int LinkWidth   = 15;
  localparam int AngleWidth  = 16;
  localparam int ElbowWidth  = 15;
  localparam int CfgIdxWidth = 2;
  localparam int CordicSteps = 16;
  localparam int TabLen      = 24;
  // Working width of the CORDIC datapath: operands are normalized to 2^40 and grow
  // by the CORDIC gain, so 44 bits carry them with sign.
  localparam int CwWidth     = 44;
  localparam int ZWidth      = 26;
  // Width of squared and product terms.
  localparam int SqWidth     = 36;
  localparam int SqrtWidth   = 64;
  localparam int RootWidth   = 32;

  typedef enum logic [1:0] {
    RegUpperLink = 2'd0,
    RegLowerLink = 2'd1,
    RegBaseX     = 2'd2,
    RegBaseY     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusTooFar = 2'd1,
    StatusTooNear = 2'd2
  } reach_status_e;

  // Front-end record handed to the back end through the queue.
  typedef struct packed {
    logic signed [CoordWidth:0] dx;
    logic signed [CoordWidth:0] dy;
    logic [LinkWidth-1:0]       l1;
    logic [LinkWidth-1:0]       l2;
    logic [1:0]                 status;
  } front_item_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] shoulder;
    logic [ElbowWidth-1:0]        elbow;
    logic [1:0]                   status;
  } result_t;

  function automatic logic [ZWidth-1:0] atan_tab(input logic [4:0] i);
    logic [ZWidth-1:0] r;
    r = '0;
    case (i)
      5'd0:  r = 26'd2097152;
      5'd1:  r = 26'd1238021;
      5'd2:  r = 26'd654136;
      5'd3:  r = 26'd332050;
      5'd4:  r = 26'd166669;
      5'd5:  r = 26'd83416;
      5'd6:  r = 26'd41718;
      5'd7:  r = 26'd20860;
      5'd8:  r = 26'd10430;
      5'd9:  r = 26'd5215;
      5'd10: r = 26'd2608;
      5'd11: r = 26'd1304;
      5'd12: r = 26'd652;
      5'd13: r = 26'd326;
      5'd14: r = 26'd163;
      5'd15: r = 26'd81;
      5'd16: r = 26'd41;
      5'd17: r = 26'd20;
      5'd18: r = 26'd10;
      5'd19: r = 26'd5;
      5'd20: r = 26'd3;
      5'd21: r = 26'd1;
      5'd22: r = 26'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/two_link_inverse_kinematics_top.sv */
// Top level of the two-link inverse kinematics block.
// Depends on tlik_pkg, tlik_front, tlik_fifo and tlik_back.
//
// Usage:
//   Configuration is written through cfg_valid_i/cfg_ready_o with a register
//   index (0 upper link, 1 lower link, 2 base x, 3 base y) and data; it is
//   always ready and must only be written while the block is idle.
//   Target beats enter on s_axis (tdata = target_x, target_y) and one result
//   beat per target leaves on m_axis (tdata = shoulder, elbow, pad; tuser =
//   reach status).
//   Throughput is one beat per cycle while the receiver accepts results. On
//   its way to a result beat, a target passes through two front stages, the
//   queue, three product stages, a root load stage, 32 square-root stages,
//   7 normalization stages, 17 CORDIC stages and two output stages.
//   Reset empties all stages and the queue and loads link lengths of 960 and
//   a base at the origin. When the receiver stalls, the back pipeline holds,
//   the queue fills, then the front stops and s_axis_tready drops.
module two_link_inverse_kinematics_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // target_x [15:0], target_y [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // shoulder_angle [15:0], elbow_angle [30:16], zero [31]
  output logic [1:0]  m_axis_tuser   // reach_status [1:0]
);
  import tlik_pkg::*;

  logic [LinkWidth-1:0]  l1_q, l2_q;
  logic signed [15:0]    bx_q, by_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= 15'd960;
      l2_q <= 15'd960;
      bx_q <= '0;
      by_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegUpperLink: l1_q <= cfg_data_i[LinkWidth-1:0];
        RegLowerLink: l2_q <= cfg_data_i[LinkWidth-1:0];
        RegBaseX:     bx_q <= cfg_data_i;
        RegBaseY:     by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        f_valid, f_ready, q_valid, q_ready;
  front_item_t f_item, q_item;
  result_t     res;

  tlik_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .target_x_i (s_axis_tdata[15:0]),
    .target_y_i (s_axis_tdata[31:16]),
    .l1_i (l1_q), .l2_i (l2_q), .base_x_i (bx_q), .base_y_i (by_q),
    .out_valid_o (f_valid), .out_ready_i (f_ready), .out_item_o (f_item)
  );

  tlik_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_item_i (f_item),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_item_o (q_item)
  );

  tlik_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid), .in_ready_o (q_ready), .in_item_i (q_item),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready), .out_res_o (res)
  );

  assign m_axis_tdata = {1'b0, res.elbow, res.shoulder};
  assign m_axis_tuser = res.status;

  // An unreachable target never reports nonzero angles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StatusOk |-> m_axis_tdata == '0)
    else $error("unreachable result carries angles");

  // The status code 3 is never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("invalid reach status");

  // A stalled output does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
endmodule

/* hdl/tlik_front.sv */
// Front end: forms the offset from the base and classifies reachability.
// Depends on tlik_pkg. Two registered stages with a valid/ready pipeline.
module tlik_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            target_x_i,
  input  logic signed [15:0]            target_y_i,
  input  logic [14:0]                   l1_i,
  input  logic [14:0]                   l2_i,
  input  logic signed [15:0]            base_x_i,
  input  logic signed [15:0]            base_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tlik_pkg::front_item_t         out_item_o
);
  import tlik_pkg::*;

  logic                       s1_valid_q;
  logic signed [CoordWidth:0] dx_q, dy_q;
  logic [LinkWidth-1:0]       l1_q, l2_q;
  logic                       s2_valid_q;
  front_item_t                item_q;
  logic                       s1_adv, s2_adv;

  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  // Stage 1: offsets from the base.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      dx_q <= {target_x_i[15], target_x_i} - {base_x_i[15], base_x_i};
      dy_q <= {target_y_i[15], target_y_i} - {base_y_i[15], base_y_i};
      l1_q <= l1_i;
      l2_q <= l2_i;
    end
  end

  // Stage 2: squared distance against the annulus bounds.
  logic [CoordWidth:0]  adx, ady;
  logic [LinkWidth:0]   reach;
  logic signed [LinkWidth:0] diff;
  logic [LinkWidth-1:0] adiff;
  logic [SqWidth-1:0]   d2, reach2, diff2;
  logic [1:0]           status_c;

  always_comb begin
    adx    = dx_q[CoordWidth] ? -dx_q : dx_q;
    ady    = dy_q[CoordWidth] ? -dy_q : dy_q;
    reach  = {1'b0, l1_q} + {1'b0, l2_q};
    diff   = $signed({1'b0, l1_q}) - $signed({1'b0, l2_q});
    adiff  = diff[LinkWidth] ? LinkWidth'(-diff) : diff[LinkWidth-1:0];
    d2     = SqWidth'(adx) * SqWidth'(adx) + SqWidth'(ady) * SqWidth'(ady);
    reach2 = SqWidth'(reach) * SqWidth'(reach);
    diff2  = SqWidth'(adiff) * SqWidth'(adiff);
    status_c = StatusOk;
    if ({1'b0, adx} > (CoordWidth+2)'(reach) || {1'b0, ady} > (CoordWidth+2)'(reach)) begin
      status_c = StatusTooFar;
    end else if (d2 > reach2) begin
      status_c = StatusTooFar;
    end else if (d2 < diff2) begin
      status_c = StatusTooNear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      item_q.dx     <= dx_q;
      item_q.dy     <= dy_q;
      item_q.l1     <= l1_q;
      item_q.l2     <= l2_q;
      item_q.status <= status_c;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = item_q;
endmodule

/* hdl/tlik_fifo.sv */
// Short queue between the front end and the back end.
// Depends on tlik_pkg. Four entries, flags decoded from a registered count.
module tlik_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  tlik_pkg::front_item_t wr_item_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output tlik_pkg::front_item_t rd_item_o
);
  import tlik_pkg::*;

  front_item_t mem_q [4];
  logic [1:0]  wptr_q, rptr_q;
  logic [2:0]  cnt_q;
  logic        wr_en, rd_en;

  assign wr_ready_o = cnt_q != 3'd4;
  assign rd_valid_o = cnt_q != 3'd0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + 2'd1;
      if (rd_en) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end
endmodule

/* hdl/tlik_back.sv */
// Back end: law of cosines, integer square root and three CORDIC arctangents.
// Depends on tlik_pkg. A fully pipelined datapath with one stall signal and an
// output register; one item may enter each cycle unless the output stalls.
module tlik_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tlik_pkg::front_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tlik_pkg::result_t     out_res_o
);
  import tlik_pkg::*;

  // Stage plan: P0 products, P1 N/D, P2 radicand product, root load, 32 root
  // steps, normalization load and 6 steps, quadrant, CordicSteps rotations,
  // finish.
  localparam int RootSteps = 32;
  localparam int NormSteps = 6;
  localparam int Depth = 3 + 1 + RootSteps + 1 + NormSteps + 1 + CordicSteps + 2;

  logic adv;
  logic [Depth-1:0] vld_q;
  logic skid_full;
  assign adv        = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = adv;
  assign skid_full  = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // P0: squares and link product.
  typedef logic signed [CwWidth-1:0] sw_t;
  logic signed [CoordWidth:0] dx0_q, dy0_q;
  logic [1:0]  st0_q;
  logic [SqWidth-1:0] dxx_q, dyy_q, l11_q, l22_q, l12_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx0_q <= in_item_i.dx;
      dy0_q <= in_item_i.dy;
      st0_q <= in_item_i.status;
      dxx_q <= SqWidth'($signed(in_item_i.dx) * $signed(in_item_i.dx));
      dyy_q <= SqWidth'($signed(in_item_i.dy) * $signed(in_item_i.dy));
      l11_q <= SqWidth'(in_item_i.l1) * SqWidth'(in_item_i.l1);
      l22_q <= SqWidth'(in_item_i.l2) * SqWidth'(in_item_i.l2);
      l12_q <= SqWidth'(in_item_i.l1) * SqWidth'(in_item_i.l2);
    end
  end

  // P1: N, D and the shoulder denominator 2 l1^2 + N.
  logic signed [CoordWidth:0] dx1_q, dy1_q;
  logic [1:0] st1_q;
  sw_t n1_q, d1_q, m1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= dx0_q;
      dy1_q <= dy0_q;
      st1_q <= st0_q;
      n1_q  <= sw_t'(dxx_q) + sw_t'(dyy_q) - sw_t'(l11_q) - sw_t'(l22_q);
      d1_q  <= sw_t'({l12_q, 1'b0});
      m1_q  <= sw_t'(dxx_q) + sw_t'(dyy_q) + sw_t'(l11_q) - sw_t'(l22_q);
    end
  end

  // P2: radicand (D-N)(D+N); both factors are nonnegative when reachable.
  // Each factor is below 2^32, so the product is split into 16-bit halves.
  logic [31:0] dm, dp;
  assign dm = 32'(d1_q - n1_q);
  assign dp = 32'(d1_q + n1_q);
  logic signed [CoordWidth:0] dx2_q, dy2_q;
  logic [1:0] st2_q;
  sw_t n2_q, m2_q;
  logic [47:0] ph_q, pl_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      st2_q <= st1_q;
      n2_q  <= n1_q;
      m2_q  <= m1_q;
      ph_q  <= 48'(dm) * 48'(dp[31:16]);
      pl_q  <= 48'(dm) * 48'(dp[15:0]);
    end
  end

  // Square root, one result bit per stage.
  typedef struct packed {
    logic signed [CoordWidth:0] dx;
    logic signed [CoordWidth:0] dy;
    logic [1:0] st;
    sw_t n;
    sw_t m;
    logic [SqrtWidth-1:0] rem;
    logic [RootWidth-1:0] root;
  } sq_t;
  sq_t sq_q [RootSteps+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].dx   <= dx2_q;
      sq_q[0].dy   <= dy2_q;
      sq_q[0].st   <= st2_q;
      sq_q[0].n    <= n2_q;
      sq_q[0].m    <= m2_q;
      sq_q[0].rem  <= {ph_q, 16'b0} + SqrtWidth'(pl_q);
      sq_q[0].root <= '0;
    end
  end
  for (genvar k = 0; k < RootSteps; k++) begin : g_sqrt
    localparam int B = RootSteps - 1 - k;
    logic [SqrtWidth-1:0] trial;
    sq_t sq_d;
    assign trial = ({32'b0, sq_q[k].root} << (B + 1)) | (SqrtWidth'(1) << (2 * B));
    always_comb begin
      sq_d = sq_q[k];
      if (sq_q[k].rem >= trial) begin
        sq_d.rem  = sq_q[k].rem - trial;
        sq_d.root = sq_q[k].root | (RootWidth'(1) << B);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[k+1] <= sq_d;
    end
  end

  // Three CORDIC lanes: 0 elbow (S, N), 1 target (dy, dx), 2 link (S, M).
  typedef struct packed {
    sw_t x;
    sw_t y;
    logic signed [ZWidth-1:0] z;
    logic zero;
  } lane_t;
  typedef struct packed {
    logic [1:0] st;
    lane_t [2:0] ln;
  } cq_t;

  // Normalization: shift left until the larger magnitude reaches 2^40,
  // in binary steps of 32, 16, 8, 4, 2, 1. A step is taken whenever the
  // shifted magnitude stays below 2^41.
  cq_t nm_q [NormSteps+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_q[0].st <= sq_q[RootSteps].st;
      nm_q[0].ln[0].x <= sq_q[RootSteps].n;
      nm_q[0].ln[0].y <= sw_t'(sq_q[RootSteps].root);
      nm_q[0].ln[1].x <= sw_t'(sq_q[RootSteps].dx);
      nm_q[0].ln[1].y <= sw_t'(sq_q[RootSteps].dy);
      nm_q[0].ln[2].x <= sq_q[RootSteps].m;
      nm_q[0].ln[2].y <= sw_t'(sq_q[RootSteps].root);
      for (int j = 0; j < 3; j++) begin
        nm_q[0].ln[j].z    <= '0;
        nm_q[0].ln[j].zero <= 1'b0;
      end
    end
  end
  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int Sh = 32 >> k;
    for (genvar j = 0; j < 3; j++) begin : g_lane
      sw_t ax, ay, mx;
      lane_t ln_d;
      always_comb begin
        ax = nm_q[k].ln[j].x[CwWidth-1] ? -nm_q[k].ln[j].x : nm_q[k].ln[j].x;
        ay = nm_q[k].ln[j].y[CwWidth-1] ? -nm_q[k].ln[j].y : nm_q[k].ln[j].y;
        mx = (ax > ay) ? ax : ay;
        ln_d = nm_q[k].ln[j];
        if (k == 0) ln_d.zero = (mx == '0);
        if (mx != '0 && mx < (sw_t'(1) <<< (41 - Sh))) begin
          ln_d.x = nm_q[k].ln[j].x <<< Sh;
          ln_d.y = nm_q[k].ln[j].y <<< Sh;
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv) nm_q[k+1].ln[j] <= ln_d;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) nm_q[k+1].st <= nm_q[k].st;
    end
  end

  // Quadrant fold and the rotation stages.
  cq_t cr_q [CordicSteps+1];
  for (genvar j = 0; j < 3; j++) begin : g_quad
    lane_t ln_d;
    always_comb begin
      ln_d = nm_q[NormSteps].ln[j];
      if (nm_q[NormSteps].ln[j].x[CwWidth-1]) begin
        if (!nm_q[NormSteps].ln[j].y[CwWidth-1]) begin
          ln_d.x = nm_q[NormSteps].ln[j].y;
          ln_d.y = -nm_q[NormSteps].ln[j].x;
          ln_d.z = ZWidth'(16384 << 8);
        end else begin
          ln_d.x = -nm_q[NormSteps].ln[j].y;
          ln_d.y = nm_q[NormSteps].ln[j].x;
          ln_d.z = -ZWidth'(16384 << 8);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) cr_q[0].ln[j] <= ln_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) cr_q[0].st <= nm_q[NormSteps].st;
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
    for (genvar j = 0; j < 3; j++) begin : g_lane
      sw_t xs, ys;
      lane_t ln_d;
      assign xs = cr_q[k].ln[j].x >>> k;
      assign ys = cr_q[k].ln[j].y >>> k;
      always_comb begin
        ln_d = cr_q[k].ln[j];
        if (!cr_q[k].ln[j].y[CwWidth-1] && cr_q[k].ln[j].y != '0) begin
          ln_d.x = cr_q[k].ln[j].x + ys;
          ln_d.y = cr_q[k].ln[j].y - xs;
          ln_d.z = cr_q[k].ln[j].z + $signed(atan_tab(5'(k)));
        end else if (cr_q[k].ln[j].y[CwWidth-1]) begin
          ln_d.x = cr_q[k].ln[j].x - ys;
          ln_d.y = cr_q[k].ln[j].y + xs;
          ln_d.z = cr_q[k].ln[j].z - $signed(atan_tab(5'(k)));
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv) cr_q[k+1].ln[j] <= ln_d;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) cr_q[k+1].st <= cr_q[k].st;
    end
  end

  // Rounding, elbow clamp, shoulder difference.
  logic signed [ZWidth-1:0] ang [3];
  for (genvar j = 0; j < 3; j++) begin : g_rnd
    logic signed [ZWidth-1:0] zr;
    assign zr     = cr_q[CordicSteps].ln[j].z + ZWidth'(128);
    assign ang[j] = cr_q[CordicSteps].ln[j].zero ? '0 : (zr >>> 8);
  end
  logic [1:0] stf_q;
  logic signed [ZWidth-1:0] a0_q, a1_q, a2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stf_q <= cr_q[CordicSteps].st;
      a0_q  <= ang[0];
      a1_q  <= ang[1];
      a2_q  <= ang[2];
    end
  end

  result_t res_q;
  logic signed [ZWidth-1:0] sh;
  assign sh = a1_q - a2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.status <= stf_q;
      if (stf_q != StatusOk) begin
        res_q.shoulder <= '0;
        res_q.elbow    <= '0;
      end else begin
        res_q.shoulder <= sh[AngleWidth-1:0];
        if (a0_q < 0)                       res_q.elbow <= '0;
        else if (a0_q > ZWidth'(32767))     res_q.elbow <= 15'h7fff;
        else                                res_q.elbow <= a0_q[ElbowWidth-1:0];
      end
    end
  end

  assign out_valid_o = skid_full;
  assign out_res_o   = res_q;
endmodule
